### design/lsm_pkg.sv
package lsm_pkg;

  // Line limit per text and the longest pattern the window can hold.
  localparam int MAX_LINES   = 256;
  localparam int PATTERN_MAX = 16;

  // Derived widths.
  localparam int LEN_W     = $clog2(PATTERN_MAX + 1);
  localparam int IDX_W     = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int RECENT_D  = (PATTERN_MAX > 1) ? PATTERN_MAX - 1 : 1;
  localparam int LINES_W   = $clog2(MAX_LINES + 1);

  // Fixed field and register widths.
  localparam int COUNT_W   = 9;
  localparam int REG_W     = 64;
  localparam int REG_IDX_W = 3;
  localparam int PLEN_W    = 5;

  // Character codes.
  localparam logic [7:0] NEWLINE     = 8'h0A;
  localparam logic [7:0] UPPER_A     = 8'h41;
  localparam logic [7:0] UPPER_Z     = 8'h5A;
  localparam logic [7:0] CASE_OFFSET = 8'd32;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_PATTERN_LOW    = 3'd0,
    REG_PATTERN_HIGH   = 3'd1,
    REG_PATTERN_LENGTH = 3'd2,
    REG_IGNORE_CASE    = 3'd3,
    REG_INVERT_MATCH   = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] line_number;
    logic               line_hit;
    logic [COUNT_W-1:0] hit_total;
    logic               last;
  } out_item_t;

  // Settings as seen by the datapath; length is already clamped.
  typedef struct packed {
    logic [PATTERN_MAX-1:0][7:0] pattern;
    logic [LEN_W-1:0]            length;
    logic                        ignore_case;
    logic                        invert_match;
  } cfg_t;

endpackage

### design/lsm_cfg.sv
module lsm_cfg import lsm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data,
  output cfg_t                 cfg
);

  logic [REG_W-1:0]   pattern_low;
  logic [REG_W-1:0]   pattern_high;
  logic [PLEN_W-1:0]  pattern_length;
  logic               ignore_case;
  logic               invert_match;
  logic [2*REG_W-1:0] pattern_all;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      pattern_length <= '0;
      ignore_case    <= 1'b0;
      invert_match   <= 1'b0;
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_PATTERN_LOW:    pattern_low    <= cfg_data;
        REG_PATTERN_HIGH:   pattern_high   <= cfg_data;
        REG_PATTERN_LENGTH: pattern_length <= cfg_data[PLEN_W-1:0];
        REG_IGNORE_CASE:    ignore_case    <= cfg_data[0];
        REG_INVERT_MATCH:   invert_match   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Lengths beyond the window behave as the longest pattern.
  always_comb begin
    pattern_all      = {pattern_high, pattern_low};
    cfg.pattern      = pattern_all[PATTERN_MAX*8-1:0];
    cfg.length       = (pattern_length > PLEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX)
                                                              : LEN_W'(pattern_length);
    cfg.ignore_case  = ignore_case;
    cfg.invert_match = invert_match;
  end

endmodule

### design/lsm_match.sv
module lsm_match import lsm_pkg::*; (
  input  cfg_t                     cfg,
  input  logic [7:0]               text_byte,
  input  logic [RECENT_D-1:0][7:0] recent,
  output logic                     window_hit
);

  function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic fold);
    if (fold && c >= UPPER_A && c <= UPPER_Z) begin
      return c + CASE_OFFSET;
    end
    return c;
  endfunction

  logic [PATTERN_MAX-1:0][7:0] win;

  // Window position 0 is the incoming byte, older bytes follow. Pattern byte k
  // lines up with the byte that is length-1-k positions back.
  always_comb begin
    logic [LEN_W-1:0] idx;
    idx    = '0;
    win[0] = text_byte;
    for (int j = 1; j < PATTERN_MAX; j++) begin
      win[j] = recent[j-1];
    end
    window_hit = (cfg.length != '0);
    for (int k = 0; k < PATTERN_MAX; k++) begin
      if (LEN_W'(k) < cfg.length) begin
        idx = cfg.length - LEN_W'(k) - LEN_W'(1);
        if (fold_byte(win[idx[IDX_W-1:0]], cfg.ignore_case) !=
            fold_byte(cfg.pattern[k], cfg.ignore_case)) begin
          window_hit = 1'b0;
        end
      end
    end
  end

endmodule

### design/lsm_scan.sv
module lsm_scan import lsm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output logic      has_result,
  output out_item_t result
);

  logic [RECENT_D-1:0][7:0] recent;
  logic [LEN_W-1:0]         bytes_in_line;
  logic                     found_in_line;
  logic [LINES_W-1:0]       lines_done;
  logic [LINES_W-1:0]       hits_done;

  logic                     window_hit;
  logic                     is_close;
  logic [LEN_W-1:0]         bytes_in_line_next;
  logic                     found_set;
  logic                     line_hit;
  logic [LINES_W-1:0]       lines_done_next;
  logic [LINES_W-1:0]       hits_done_next;

  lsm_match u_match (
    .cfg        (cfg),
    .text_byte  (item.text_byte),
    .recent     (recent),
    .window_hit (window_hit)
  );

  always_comb begin
    is_close           = item.end_of_text || (item.text_byte == NEWLINE);
    bytes_in_line_next = (bytes_in_line < LEN_W'(PATTERN_MAX)) ? bytes_in_line + LEN_W'(1)
                                                               : bytes_in_line;
    // The window only counts once it lies fully inside the current line.
    found_set          = window_hit && (bytes_in_line_next >= cfg.length);
    line_hit           = ((cfg.length == '0) || found_in_line) ^ cfg.invert_match;
    lines_done_next    = lines_done + LINES_W'(1);
    hits_done_next     = hits_done + LINES_W'(line_hit);
    has_result         = is_close && (lines_done < LINES_W'(MAX_LINES));

    result.line_number = COUNT_W'(lines_done_next);
    result.line_hit    = line_hit;
    result.hit_total   = COUNT_W'(hits_done_next);
    result.last        = item.end_of_text;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_in_line <= '0;
      found_in_line <= 1'b0;
      lines_done    <= '0;
      hits_done     <= '0;
    end else if (step) begin
      if (!is_close) begin
        bytes_in_line <= bytes_in_line_next;
        if (found_set) begin
          found_in_line <= 1'b1;
        end
      end else begin
        bytes_in_line <= '0;
        found_in_line <= 1'b0;
        if (item.end_of_text) begin
          lines_done <= '0;
          hits_done  <= '0;
        end else if (has_result) begin
          lines_done <= lines_done_next;
          hits_done  <= hits_done_next;
        end
      end
    end
  end

  // Recent bytes that closed no line, newest first.
  always_ff @(posedge clk) begin
    if (step && !is_close) begin
      recent[0] <= item.text_byte;
      for (int i = 1; i < RECENT_D; i++) begin
        recent[i] <= recent[i-1];
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_lines_bounded: assert property (@(posedge clk) disable iff (rst)
    lines_done <= LINES_W'(MAX_LINES))
    else $error("line counter passed the line limit");

  a_hits_bounded: assert property (@(posedge clk) disable iff (rst)
    hits_done <= lines_done)
    else $error("hit counter exceeds line counter");
`endif

endmodule

### design/line_substring_matcher.sv
// Fixed-pattern line search over a byte stream.
// Input channel (in_valid / in_ready / in_data): one request per text byte, or
// one request with end_of_text set to close the final line. A newline byte
// closes a line and is not part of it. Each line is searched for the pattern
// held in the configuration registers, written through cfg_write, cfg_index
// and cfg_data while the block is idle.
// Output channel (out_valid / out_ready / out_data): one request per closed
// line, carrying the line number, the hit flag and the running hit count; the
// request closed by end of text has last set. Lines past the line limit give
// no request. After end of text the line and hit counters restart.
// Pipeline: a taken request waits in the input register; when it is processed
// its result is written into the output register for the receiver.
// Throughput: one request per cycle, except while a closing request waits for
// the output register; compare and counter updates form the one compute stage.
// Stall: while out_ready is low the output register holds its result, and the
// block keeps taking bytes that close no line; a closing request waits in the
// input register until the output register frees up.
// Reset (rst, synchronous): clears the configuration registers, the line
// state and counters, and both valids.
module line_substring_matcher import lsm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data
);

  cfg_t      cfg;
  logic      hold_valid;
  in_item_t  hold_item;
  logic      step;
  logic      has_result;
  out_item_t result;

  lsm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lsm_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .item       (hold_item),
    .cfg        (cfg),
    .has_result (has_result),
    .result     (result)
  );

  // The held request is processed when it produces nothing or when the output
  // register is empty or being emptied in this cycle.
  always_comb begin
    step     = hold_valid && (!has_result || !out_valid || out_ready);
    in_ready = !hold_valid || step;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      hold_valid <= 1'b1;
    end else if (step) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_item <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && has_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && has_result) begin
      out_data <= result;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (step && has_result) |-> (!out_valid || out_ready))
    else $error("result written over an untaken result");

  a_hit_counted: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.line_hit) |->
      (out_data.hit_total != '0 && out_data.hit_total <= out_data.line_number))
    else $error("hit count inconsistent with line hit");
`endif

endmodule

### tb/line_substring_matcher_test.sv
`timescale 1ns / 100ps

module line_substring_matcher_test;
  import lsm_pkg::*;

  // Cycles to let a byte that closes no line drain out of the two-stage pipe.
  localparam int PIPE_SETTLE = 8;
  // Rough number of requests for the whole run.
  localparam int ITEM_TARGET = 1450;

  typedef enum {ROW_CFG, ROW_ITEM} row_kind_t;
  typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_BLOCKS} rx_mode_t;

  // One row of the directed table. A row either writes a register or sends a
  // request; a request row may carry its line report typed in by hand.
  typedef struct {
    row_kind_t    kind;
    reg_index_t   idx;
    logic [REG_W-1:0] data;
    in_item_t     req;
    bit           typed;
    out_item_t    want;
  } stim_row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_write = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  in_item_t         in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_item_t        out_data;

  line_substring_matcher u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #(5_000_000);
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Predictor state. It mirrors the block's settings as written and its
  // line state: the window of recent bytes (newest first), how many bytes
  // the current line holds (saturating at the pattern maximum), whether the
  // pattern was already seen, and the per-text line and hit counters.
  // ---------------------------------------------------------------------
  logic [PATTERN_MAX-1:0][7:0] pat_bytes = '0;
  logic [PLEN_W-1:0]           pat_len_reg = '0;
  logic                        fold_on = 1'b0;
  logic                        invert_on = 1'b0;

  logic [7:0]        win_bytes [RECENT_D] = '{default: '0};
  logic [LEN_W-1:0]  line_fill = '0;
  logic              line_found = 1'b0;
  logic [LINES_W-1:0] lines_closed = '0;
  logic [LINES_W-1:0] hits_counted = '0;

  // Line reports the block still owes us, oldest first.
  out_item_t pending_lines [$];

  int failures = 0;
  int requests_sent = 0;
  int reports_seen = 0;
  int hits_seen = 0;
  int finals_seen = 0;
  int settings_used = 0;
  int burst_left = 0;

  // Pattern length as the datapath uses it: anything above the window size
  // counts as a full-window pattern.
  function automatic int used_length();
    return (pat_len_reg > PATTERN_MAX) ? PATTERN_MAX : int'(pat_len_reg);
  endfunction

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    if (fold_on && c >= UPPER_A && c <= UPPER_Z)
      return c + CASE_OFFSET;
    return c;
  endfunction

  // Advances the predictor by one request. Returns 1 and fills rpt when the
  // request closes a line that is still under the line limit.
  function automatic bit scan_request(input in_item_t req, output out_item_t rpt);
    int plen;
    int k;
    int i;
    int back;
    bit same;
    bit hit;
    bit produced;
    logic [7:0] t;
    rpt = '0;
    produced = 1'b0;
    plen = used_length();
    if (!req.end_of_text && req.text_byte != NEWLINE) begin
      // An ordinary byte ends a window of pattern length; the window must
      // lie wholly inside the current line.
      if (line_fill < PATTERN_MAX)
        line_fill++;
      if (plen > 0 && line_fill >= plen) begin
        same = 1'b1;
        for (k = 0; k < plen; k++) begin
          back = plen - 1 - k;
          t = (back == 0) ? req.text_byte : win_bytes[back - 1];
          if (fold_case(t) != fold_case(pat_bytes[k]))
            same = 1'b0;
        end
        if (same)
          line_found = 1'b1;
      end
      for (i = RECENT_D - 1; i > 0; i--)
        win_bytes[i] = win_bytes[i - 1];
      win_bytes[0] = req.text_byte;
    end else begin
      // A newline or end of text closes the line. Past the line limit the
      // line is dropped silently.
      if (lines_closed < MAX_LINES) begin
        hit = (plen == 0) || line_found;
        if (invert_on)
          hit = !hit;
        lines_closed++;
        if (hit)
          hits_counted++;
        rpt.line_number = COUNT_W'(lines_closed);
        rpt.line_hit    = hit;
        rpt.hit_total   = COUNT_W'(hits_counted);
        rpt.last        = req.end_of_text;
        produced = 1'b1;
      end
      win_bytes = '{default: '0};
      line_fill = '0;
      line_found = 1'b0;
      if (req.end_of_text) begin
        lines_closed = '0;
        hits_counted = '0;
      end
    end
    return produced;
  endfunction

  // ---------------------------------------------------------------------
  // Request side. The sender works in bursts; between bursts it drops valid
  // for a random gap, sometimes none at all, and now and then runs a long
  // burst with no gaps so the pipe sees back-to-back traffic.
  // ---------------------------------------------------------------------
  task automatic drive_request(input in_item_t req);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 20);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    requests_sent++;
  endtask

  task automatic send_request(input in_item_t req);
    out_item_t rpt;
    if (scan_request(req, rpt))
      pending_lines.push_back(rpt);
    drive_request(req);
  endtask

  // Holds the sender off until every owed report has arrived, then lets the
  // pipe settle, since a trailing byte produces no report to wait for.
  task automatic wait_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_lines.size() != 0) @(posedge clk);
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  // Writes one register and mirrors it into the predictor. The write enable
  // is left high so back-to-back writes follow without a gap; the caller
  // drops it after the last write of a batch.
  task automatic write_reg(input reg_index_t idx, input logic [REG_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      REG_PATTERN_LOW:    pat_bytes[7:0]  = value;
      REG_PATTERN_HIGH:   pat_bytes[15:8] = value;
      REG_PATTERN_LENGTH: pat_len_reg = value[PLEN_W-1:0];
      REG_IGNORE_CASE:    fold_on = value[0];
      REG_INVERT_MATCH:   invert_on = value[0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [REG_W-1:0] lo, input logic [REG_W-1:0] hi,
                                input logic [PLEN_W-1:0] len, input logic ic,
                                input logic inv);
    wait_idle();
    write_reg(REG_PATTERN_LOW, lo);
    write_reg(REG_PATTERN_HIGH, hi);
    write_reg(REG_PATTERN_LENGTH, REG_W'(len));
    write_reg(REG_IGNORE_CASE, REG_W'(ic));
    write_reg(REG_INVERT_MATCH, REG_W'(inv));
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  // Mostly a small alphabet so that lines and patterns collide often, with
  // a few arbitrary bytes and the occasional newline mixed in.
  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 39);
    if (r == 0)
      return NEWLINE;
    if (r < 5)
      return 8'($urandom_range(0, 255));
    if (r < 22)
      return 8'("a" + $urandom_range(0, 2));
    return 8'("A" + $urandom_range(0, 2));
  endfunction

  // Flips the case of a letter now and then, which is a hit under case
  // folding and a near miss without it.
  function automatic logic [7:0] vary_case(input logic [7:0] c);
    logic [7:0] up;
    up = c & ~CASE_OFFSET;
    if (up >= UPPER_A && up <= UPPER_Z && $urandom_range(0, 3) == 0)
      return c ^ CASE_OFFSET;
    return c;
  endfunction

  // Sends one line: random bytes, often seasoned with pattern bytes and in
  // about a third of the lines with the whole pattern planted somewhere,
  // then closed by a newline or by end of text.
  task automatic send_line(input int max_len, input bit close_eot);
    logic [7:0] body [$];
    in_item_t req;
    int n;
    int j;
    int k;
    int pos;
    int plen;
    plen = used_length();
    n = $urandom_range(0, max_len);
    for (j = 0; j < n; j++) begin
      if (plen > 0 && $urandom_range(0, 2) == 0)
        body.push_back(vary_case(pat_bytes[$urandom_range(0, plen - 1)]));
      else
        body.push_back(pick_char());
    end
    if (plen > 0 && $urandom_range(0, 2) == 0) begin
      pos = $urandom_range(0, n);
      for (k = plen - 1; k >= 0; k--)
        body.insert(pos, vary_case(pat_bytes[k]));
    end
    for (j = 0; j < body.size(); j++) begin
      req.text_byte = body[j];
      req.end_of_text = 1'b0;
      send_request(req);
    end
    // The byte that rides along with end of text is ignored by the block,
    // so it is left random.
    req.text_byte = close_eot ? 8'($urandom_range(0, 255)) : NEWLINE;
    req.end_of_text = close_eot;
    send_request(req);
  endtask

  // One random phase: new settings, then a few texts under them. Some phases
  // pin the extremes; phase 3 runs one text past the line limit with an
  // empty pattern so that the counters reach their top values.
  task automatic run_random_phase(input int phase);
    logic [PATTERN_MAX-1:0][7:0] pat;
    logic [REG_W-1:0] lo;
    logic [REG_W-1:0] hi;
    logic [PLEN_W-1:0] len;
    logic ic;
    logic inv;
    int texts;
    int lines;
    int tx;
    int ln;
    int max_len;
    for (int k = 0; k < PATTERN_MAX; k++)
      pat[k] = pick_char();
    lo = pat[7:0];
    hi = pat[15:8];
    ic = 1'($urandom_range(0, 1));
    inv = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0:       len = '0;
      1:       len = PLEN_W'(PATTERN_MAX);
      2:       len = PLEN_W'($urandom_range(PATTERN_MAX + 1, 31));
      default: len = PLEN_W'($urandom_range(1, 6));
    endcase
    texts = $urandom_range(1, 3);
    max_len = 10;
    if (phase == 3) begin
      len = '0;
      inv = 1'b0;
      texts = 1;
      max_len = 1;
    end else if (phase % 6 == 0) begin
      len = PLEN_W'(PATTERN_MAX);
      ic = 1'b1;
      max_len = 24;
    end else if (phase % 6 == 1) begin
      len = '0;
      inv = 1'b1;
    end else if (phase % 6 == 2) begin
      // Arbitrary register contents, so every register bit toggles.
      lo = {$urandom, $urandom};
      hi = {$urandom, $urandom};
      len = PLEN_W'($urandom_range(0, 31));
    end
    apply_settings(lo, hi, len, ic, inv);
    for (tx = 0; tx < texts; tx++) begin
      lines = (phase == 3) ? $urandom_range(MAX_LINES + 1, MAX_LINES + 40)
                           : $urandom_range(1, 10);
      for (ln = 0; ln < lines; ln++) begin
        // Now and then a text is left open at its end, so the next one
        // carries on counting lines from where it stopped.
        send_line(max_len, (ln == lines - 1) && ($urandom_range(0, 7) != 0 || phase == 3));
      end
    end
  endtask

  function automatic stim_row_t cfg_row(input reg_index_t idx, input logic [REG_W-1:0] value);
    stim_row_t r;
    r = '{kind: ROW_CFG, idx: idx, data: value, req: '0, typed: 1'b0, want: '0};
    return r;
  endfunction

  function automatic stim_row_t item_row(input logic [7:0] b, input logic eot);
    stim_row_t r;
    r = '{kind: ROW_ITEM, idx: REG_PATTERN_LOW, data: '0, req: '0, typed: 1'b0, want: '0};
    r.req.text_byte = b;
    r.req.end_of_text = eot;
    return r;
  endfunction

  function automatic stim_row_t report_row(input logic [7:0] b, input logic eot,
                                          input int line_no, input logic hit,
                                          input int total, input logic fin);
    stim_row_t r;
    r = item_row(b, eot);
    r.typed = 1'b1;
    r.want.line_number = COUNT_W'(line_no);
    r.want.line_hit = hit;
    r.want.hit_total = COUNT_W'(total);
    r.want.last = fin;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Main sequence: reset, the directed table, then random phases.
  // ---------------------------------------------------------------------
  initial begin
    stim_row_t rows [$];
    out_item_t scratch;
    int phase;

    // After reset the pattern is empty, so every line is a hit. End of text
    // wins over a newline byte riding along with it.
    rows.push_back(report_row(NEWLINE, 1'b1, 1, 1'b1, 1, 1'b1));
    rows.push_back(item_row(8'hFF, 1'b0));
    rows.push_back(report_row(NEWLINE, 1'b0, 1, 1'b1, 1, 1'b0));
    // End of text right after a newline still closes an empty final line.
    rows.push_back(report_row(8'h00, 1'b1, 2, 1'b1, 2, 1'b1));

    // "abc" with case folding; the high word is all ones but unused.
    rows.push_back(cfg_row(REG_PATTERN_LOW, 64'h0000_0000_0063_6261));
    rows.push_back(cfg_row(REG_PATTERN_HIGH, '1));
    rows.push_back(cfg_row(REG_PATTERN_LENGTH, 64'd3));
    rows.push_back(cfg_row(REG_IGNORE_CASE, 64'd1));
    rows.push_back(cfg_row(REG_INVERT_MATCH, 64'd0));
    rows.push_back(item_row("A", 1'b0));
    rows.push_back(item_row("b", 1'b0));
    rows.push_back(item_row("C", 1'b0));
    rows.push_back(report_row(NEWLINE, 1'b0, 1, 1'b1, 1, 1'b0));
    rows.push_back(item_row("a", 1'b0));
    rows.push_back(item_row("b", 1'b0));
    rows.push_back(report_row(8'h00, 1'b1, 2, 1'b0, 1, 1'b1));

    // Oversized length clamps to a full window of "z"; a found line is
    // inverted away.
    rows.push_back(cfg_row(REG_PATTERN_LOW, 64'h7A7A_7A7A_7A7A_7A7A));
    rows.push_back(cfg_row(REG_PATTERN_HIGH, 64'h7A7A_7A7A_7A7A_7A7A));
    rows.push_back(cfg_row(REG_PATTERN_LENGTH, 64'd31));
    rows.push_back(cfg_row(REG_IGNORE_CASE, 64'd0));
    rows.push_back(cfg_row(REG_INVERT_MATCH, 64'd1));
    repeat (PATTERN_MAX) rows.push_back(item_row("z", 1'b0));
    rows.push_back(report_row(8'h00, 1'b1, 1, 1'b0, 0, 1'b1));

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        if (i == 0 || rows[i - 1].kind != ROW_CFG) begin
          wait_idle();
          settings_used++;
        end
        write_reg(rows[i].idx, rows[i].data);
      end else begin
        if (cfg_write)
          cfg_write <= 1'b0;
        if (rows[i].typed) begin
          // Keep the predictor in step, but check against the typed value.
          void'(scan_request(rows[i].req, scratch));
          pending_lines.push_back(rows[i].want);
          drive_request(rows[i].req);
        end else begin
          send_request(rows[i].req);
        end
      end
    end

    // The phase past the line limit always runs, however long the early
    // phases turn out.
    phase = 0;
    while (requests_sent < ITEM_TARGET || phase <= 3) begin
      run_random_phase(phase);
      phase++;
    end

    wait_idle();
    $display("Sent %0d requests under %0d pattern settings, including a text past the line limit.",
             requests_sent, settings_used);
    $display("Checked %0d line reports: %0d hits, %0d closed by end of text.",
             reports_seen, hits_seen, finals_seen);
    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // ---------------------------------------------------------------------
  // Report side. The receiver changes its mood every so often: always
  // ready, coin flips, ready on periodic ticks only, or stalls that alternate with equal ready stretches.
  // ---------------------------------------------------------------------
  int rx_tick = 0;
  rx_mode_t rx_mode = RX_OPEN;

  always @(posedge clk) begin
    rx_tick++;
    if (rx_tick % 89 == 0)
      rx_mode = rx_mode_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN:   out_ready <= 1'b1;
      RX_COIN:   out_ready <= ($urandom_range(0, 1) == 1);
      RX_SPARSE: out_ready <= (rx_tick % 4 == 0);
      default:   out_ready <= ((rx_tick / 8) % 2 == 0);
    endcase
  end

  // Every accepted report is matched against the oldest one owed.
  out_item_t oldest_report;

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      reports_seen++;
      if (out_data.line_hit)
        hits_seen++;
      if (out_data.last)
        finals_seen++;
      if (pending_lines.size() == 0) begin
        $error("line report with none owed: line_number %0d", out_data.line_number);
        failures++;
      end else begin
        oldest_report = pending_lines.pop_front();
        if (out_data.line_number !== oldest_report.line_number) begin
          $error("line_number: expected %0d, got %0d",
                 oldest_report.line_number, out_data.line_number);
          failures++;
        end
        if (out_data.line_hit !== oldest_report.line_hit) begin
          $error("line_hit: expected %0d, got %0d",
                 oldest_report.line_hit, out_data.line_hit);
          failures++;
        end
        if (out_data.hit_total !== oldest_report.hit_total) begin
          $error("hit_total: expected %0d, got %0d",
                 oldest_report.hit_total, out_data.hit_total);
          failures++;
        end
        if (out_data.last !== oldest_report.last) begin
          $error("last: expected %0d, got %0d", oldest_report.last, out_data.last);
          failures++;
        end
      end
    end
  end

endmodule
